// File: src/locd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order detector package
// Table sizes, index types and status codes shared by the detector.
// ----------------------------------------------------------------------------
package locd_pkg;

  localparam int unsigned NumMutexes = 16;
  localparam int unsigned NumThreads = 16;
  localparam int unsigned HeldDepth  = 8;

  localparam int unsigned MutexIdxW  = $clog2(NumMutexes);
  localparam int unsigned ThreadIdxW = $clog2(NumThreads);
  localparam int unsigned HeldIdxW   = $clog2(HeldDepth);
  localparam int unsigned HeldCntW   = $clog2(HeldDepth + 1);
  localparam int unsigned StepCntW   = $clog2(NumMutexes + 2);
  localparam int unsigned HeldMemW   = ThreadIdxW + HeldIdxW;

  typedef logic [MutexIdxW-1:0]  mutex_idx_t;
  typedef logic [ThreadIdxW-1:0] thread_idx_t;
  typedef logic [HeldIdxW-1:0]   held_idx_t;
  typedef logic [HeldCntW-1:0]   held_cnt_t;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StTableFull = 2'd1,
    StHeldFull  = 2'd2,
    StUnknown   = 2'd3
  } status_e;

endpackage

// File: src/lock_order_cycle_detector_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lock-order cycle detector
// Keeps mutex and thread tables and per-thread held lists, and walks the
// next-lock pointers after each lock to find a cycle.
// ----------------------------------------------------------------------------
// A lock result waits on a scan of both tables through the single key comparator,
// the held-list read and write of the previous entry, and the pointer walk; an
// unlock result waits on the table scan and the held-list search and shift.
// Throughput: one transaction at a time; busy is high until the result strobe.
// Reset clears flags, counts and valid bits at once; the receiver cannot stall.
module lock_order_cycle_detector_core
  import locd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        command_i,
  input  logic [63:0] thread_id_i,
  input  logic [63:0] mutex_id_i,
  input  logic [63:0] code_address_i,
  output logic        done_o,
  output logic        cycle_found_o,
  output logic [63:0] report_address_o,
  output logic [1:0]  status_o
);

  typedef enum logic [10:0] {
    SIdle   = 11'b00000000001,
    SFindM  = 11'b00000000010,
    SFindT  = 11'b00000000100,
    SDecide = 11'b00000001000,
    SPrevRd = 11'b00000010000,
    SPrevWr = 11'b00000100000,
    SWalk   = 11'b00001000000,
    SUlRd   = 11'b00010000000,
    SUlCmp  = 11'b00100000000,
    SUlMove = 11'b01000000000,
    SDone   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  logic [63:0] mutex_key_q [NumMutexes];
  logic [NumMutexes-1:0] mutex_used_q;
  logic [NumMutexes-1:0] next_vld_q;
  mutex_idx_t next_idx_q [NumMutexes];
  logic [63:0] thread_key_q [NumThreads];
  logic [NumThreads-1:0] thread_used_q;
  held_cnt_t held_count_q [NumThreads];
  logic [NumMutexes-1:0] visited_q;
  mutex_idx_t held_mem [NumThreads*HeldDepth];

  logic        cmd_q;
  logic [63:0] tid_q, mid_q, addr_q;
  logic [StepCntW-1:0] scan_q;
  logic        m_hit_q, t_hit_q, m_free_ok_q, t_free_ok_q;
  mutex_idx_t  m_slot_q, m_free_q, start_q, cur_q;
  thread_idx_t t_slot_q, t_free_q;
  logic [StepCntW-1:0] steps_q;
  held_cnt_t   hi_q;
  held_cnt_t   cnt_q;
  mutex_idx_t  rd_q;
  logic        found_q;
  logic [1:0]  st_q;
  logic        done_q;

  logic mem_we;
  logic [HeldMemW-1:0] mem_wa, mem_ra;
  mutex_idx_t mem_wd;

  logic [63:0] cmp_a, cmp_b;
  logic        cmp_eq;
  assign cmp_eq = (cmp_a == cmp_b);

  always_comb begin
    cmp_a = mid_q;
    cmp_b = mutex_key_q[scan_q[MutexIdxW-1:0]];
    if (state_q == SFindT) begin
      cmp_a = tid_q;
      cmp_b = thread_key_q[scan_q[ThreadIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      held_mem[mem_wa] <= mem_wd;
    end
    rd_q <= held_mem[mem_ra];
  end

  assign busy = (state_q != SIdle);

  always_comb begin
    state_d = state_q;
    mem_we  = 1'b0;
    mem_wa  = {t_slot_q, cnt_q[HeldIdxW-1:0]};
    mem_wd  = m_slot_q;
    mem_ra  = {t_slot_q, hi_q[HeldIdxW-1:0]};
    case (state_q)
      SIdle:   if (start) state_d = SFindM;
      SFindM:  if (scan_q == StepCntW'(NumMutexes - 1)) state_d = SFindT;
      SFindT:  if (scan_q == StepCntW'(NumThreads - 1)) state_d = SDecide;
      SDecide: begin
        if (cmd_q) begin
          if (!(m_hit_q || m_free_ok_q) || !(t_hit_q || t_free_ok_q)) state_d = SDone;
          else if (t_hit_q && held_count_q[t_slot_q] >= held_cnt_t'(HeldDepth))
            state_d = SDone;
          else state_d = SPrevRd;
        end else if (!m_hit_q || !t_hit_q) begin
          state_d = SDone;
        end else begin
          state_d = SUlRd;
        end
      end
      SPrevRd: begin
        mem_we = 1'b1;
        mem_ra = {t_slot_q, held_idx_t'(cnt_q - 1'b1)};
        state_d = SPrevWr;
      end
      SPrevWr: state_d = SWalk;
      SWalk: begin
        if (found_q || (start_q == mutex_idx_t'(NumMutexes - 1)
            && (!mutex_used_q[start_q] || visited_q[cur_q] || !next_vld_q[cur_q]
                || steps_q == StepCntW'(NumMutexes)))) begin
          state_d = SDone;
        end
      end
      SUlRd:  state_d = SUlCmp;
      SUlCmp: begin
        if (held_cnt_t'(hi_q) >= cnt_q) state_d = SDone;
        else if (rd_q == m_slot_q) state_d = SUlMove;
        else state_d = SUlRd;
      end
      SUlMove: begin
        mem_ra = {t_slot_q, held_idx_t'(scan_q)};
        mem_we = (scan_q > StepCntW'(hi_q) + StepCntW'(1));
        mem_wa = {t_slot_q, held_idx_t'(scan_q - StepCntW'(2))};
        mem_wd = rd_q;
        if (held_cnt_t'(scan_q) >= cnt_q) state_d = SUlRd;
      end
      SDone:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      mutex_used_q  <= '0;
      next_vld_q    <= '0;
      thread_used_q <= '0;
      visited_q     <= '0;
      done_q        <= 1'b0;
      for (int i = 0; i < NumThreads; i++) held_count_q[i] <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SDone);
      case (state_q)
        SIdle: begin
          scan_q <= '0;
          m_hit_q <= 1'b0; t_hit_q <= 1'b0;
          m_free_ok_q <= 1'b0; t_free_ok_q <= 1'b0;
          found_q <= 1'b0; st_q <= StOk;
          cmd_q <= command_i; tid_q <= thread_id_i;
          mid_q <= mutex_id_i; addr_q <= code_address_i;
        end
        SFindM: begin
          if (mutex_used_q[scan_q[MutexIdxW-1:0]] && cmp_eq && !m_hit_q) begin
            m_hit_q <= 1'b1; m_slot_q <= scan_q[MutexIdxW-1:0];
          end
          if (!mutex_used_q[scan_q[MutexIdxW-1:0]] && !m_free_ok_q) begin
            m_free_ok_q <= 1'b1; m_free_q <= scan_q[MutexIdxW-1:0];
          end
          scan_q <= (state_d == SFindT) ? '0 : scan_q + 1'b1;
        end
        SFindT: begin
          if (thread_used_q[scan_q[ThreadIdxW-1:0]] && cmp_eq && !t_hit_q) begin
            t_hit_q <= 1'b1; t_slot_q <= scan_q[ThreadIdxW-1:0];
          end
          if (!thread_used_q[scan_q[ThreadIdxW-1:0]] && !t_free_ok_q) begin
            t_free_ok_q <= 1'b1; t_free_q <= scan_q[ThreadIdxW-1:0];
          end
          scan_q <= scan_q + 1'b1;
        end
        SDecide: begin
          hi_q <= '0;
          cnt_q <= t_hit_q ? held_count_q[t_slot_q] : '0;
          if (!m_hit_q) m_slot_q <= m_free_q;
          if (!t_hit_q) t_slot_q <= t_free_q;
          if (cmd_q) begin
            if (!(m_hit_q || m_free_ok_q) || !(t_hit_q || t_free_ok_q)) st_q <= StTableFull;
            else if (t_hit_q && held_count_q[t_slot_q] >= held_cnt_t'(HeldDepth))
              st_q <= StHeldFull;
          end else if (!m_hit_q || !t_hit_q) begin
            st_q <= StUnknown;
          end
        end
        SPrevRd: begin
          if (!m_hit_q) begin
            mutex_used_q[m_slot_q] <= 1'b1;
            mutex_key_q[m_slot_q]  <= mid_q;
            next_vld_q[m_slot_q]   <= 1'b0;
          end
          if (!t_hit_q) begin
            thread_used_q[t_slot_q] <= 1'b1;
            thread_key_q[t_slot_q]  <= tid_q;
          end
          held_count_q[t_slot_q] <= cnt_q + 1'b1;
        end
        SPrevWr: begin
          if (cnt_q != '0) begin
            next_vld_q[rd_q] <= 1'b1;
            next_idx_q[rd_q] <= m_slot_q;
          end
          start_q <= '0; cur_q <= '0; steps_q <= '0; visited_q <= '0;
        end
        SWalk: begin
          if (!mutex_used_q[start_q] || visited_q[cur_q] || !next_vld_q[cur_q]
              || steps_q == StepCntW'(NumMutexes)) begin
            if (mutex_used_q[start_q] && visited_q[cur_q]) found_q <= 1'b1;
            visited_q <= '0;
            start_q <= start_q + 1'b1;
            cur_q   <= start_q + 1'b1;
            steps_q <= '0;
          end else begin
            visited_q[cur_q] <= 1'b1;
            cur_q   <= next_idx_q[cur_q];
            steps_q <= steps_q + 1'b1;
          end
        end
        SUlCmp: begin
          if (held_cnt_t'(hi_q) < cnt_q && rd_q == m_slot_q) begin
            scan_q <= StepCntW'(hi_q) + 1'b1;
          end else begin
            hi_q <= hi_q + 1'b1;
          end
          if (held_cnt_t'(hi_q) >= cnt_q) held_count_q[t_slot_q] <= cnt_q;
        end
        SUlMove: begin
          if (held_cnt_t'(scan_q) >= cnt_q) begin
            cnt_q <= cnt_q - 1'b1;
            hi_q  <= hi_q + 1'b1;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Shifted entry is registered and arrives in the cycle after its read; the move loop writes
  // the previous read into the slot below.
  assign done_o           = done_q;
  assign cycle_found_o    = done_q & found_q;
  assign report_address_o = (done_q && found_q) ? addr_q : 64'd0;
  assign status_o         = done_q ? st_q : StOk;

`ifndef ASSERT_OFF
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");
  a_cycle_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cycle_found_o |-> status_o == StOk) else $error("cycle with error status");
  a_unlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !cmd_q) |-> !cycle_found_o) else $error("unlock reported cycle");
`endif

endmodule
